### rtl/core/clr_pkg.sv
package clr_pkg;

    // field widths
    localparam int COORD_BITS  = 16;
    localparam int COLOR_BITS  = 16;
    localparam int AREA_BITS   = 15;
    localparam int OFFSET_BITS = 30;
    localparam int ERR_BITS    = COORD_BITS + 3;
    localparam int WIDTH_BITS  = AREA_BITS + 1;
    localparam int CFG_IDX_BITS = 2;
    localparam int EXT_BITS    = COORD_BITS + 1;

    // operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // area reset values
    localparam logic [AREA_BITS-1:0] AREA_LEFT_RST   = AREA_BITS'(0);
    localparam logic [AREA_BITS-1:0] AREA_TOP_RST    = AREA_BITS'(0);
    localparam logic [AREA_BITS-1:0] AREA_RIGHT_RST  = AREA_BITS'(1023);
    localparam logic [AREA_BITS-1:0] AREA_BOTTOM_RST = AREA_BITS'(767);

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_AREA_LEFT,
        REG_AREA_TOP,
        REG_AREA_RIGHT,
        REG_AREA_BOTTOM
    } t_reg_idx;

    // command kinds passed from front to back
    typedef enum logic [1:0] {
        CMD_STEP,
        CMD_LOAD,
        CMD_REJECT
    } t_cmd_kind;

    typedef struct packed {
        logic                         operation;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic [COLOR_BITS-1:0]        color;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic [OFFSET_BITS-1:0]       pixel_offset;
        logic [COLOR_BITS-1:0]        pixel_color;
        logic                         write_enable;
        logic                         last_pixel;
    } t_out_item;

    typedef struct packed {
        logic [AREA_BITS-1:0] left;
        logic [AREA_BITS-1:0] top;
        logic [AREA_BITS-1:0] right;
        logic [AREA_BITS-1:0] bottom;
    } t_area;

    // one classified request in the queue
    typedef struct packed {
        t_cmd_kind                    kind;
        logic signed [COORD_BITS-1:0] first_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic signed [COORD_BITS-1:0] major_end;
        logic [COORD_BITS-1:0]        major_delta;
        logic [COORD_BITS-1:0]        minor_delta;
        logic                         step_x_negative;
        logic                         step_y_negative;
        logic                         x_is_major;
        logic [COLOR_BITS-1:0]        color;
    } t_cmd;

    // queue handshake from the back end
    typedef struct packed {
        logic pop;
    } t_q_ctrl;

    // signed coordinate against unsigned area edge
    function automatic logic coord_lt_area(input logic signed [COORD_BITS-1:0] c,
                                           input logic [AREA_BITS-1:0] a);
        logic signed [EXT_BITS-1:0] ce;
        logic signed [EXT_BITS-1:0] ae;
        ce = {c[COORD_BITS-1], c};
        ae = $signed({{(EXT_BITS-AREA_BITS){1'b0}}, a});
        return ce < ae;
    endfunction

    function automatic logic coord_gt_area(input logic signed [COORD_BITS-1:0] c,
                                           input logic [AREA_BITS-1:0] a);
        logic signed [EXT_BITS-1:0] ce;
        logic signed [EXT_BITS-1:0] ae;
        ce = {c[COORD_BITS-1], c};
        ae = $signed({{(EXT_BITS-AREA_BITS){1'b0}}, a});
        return ce > ae;
    endfunction

endpackage

### rtl/core/clr_front.sv
module clr_front
    import clr_pkg::*;
(
    input  logic     i_in_valid,
    input  logic     i_in_ready,
    input  t_in_item i_in_data,
    input  t_area    i_area,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic signed [COORD_BITS-1:0] lx, hx, ly, hy;
    logic signed [EXT_BITS-1:0]   dx, dy;
    logic [COORD_BITS-1:0]        adx, ady;
    logic                         miss;
    logic                         x_major;

    assign o_push = i_in_valid && i_in_ready;

    // bounding box of the line and area miss test
    always_comb begin
        lx = (i_in_data.start_x < i_in_data.end_x) ? i_in_data.start_x : i_in_data.end_x;
        hx = (i_in_data.start_x < i_in_data.end_x) ? i_in_data.end_x : i_in_data.start_x;
        ly = (i_in_data.start_y < i_in_data.end_y) ? i_in_data.start_y : i_in_data.end_y;
        hy = (i_in_data.start_y < i_in_data.end_y) ? i_in_data.end_y : i_in_data.start_y;
        miss = coord_lt_area(hx, i_area.left) || coord_gt_area(lx, i_area.right)
            || coord_lt_area(hy, i_area.top) || coord_gt_area(ly, i_area.bottom);
    end

    // deltas, their magnitudes and the major axis
    always_comb begin
        dx  = {i_in_data.end_x[COORD_BITS-1], i_in_data.end_x}
            - {i_in_data.start_x[COORD_BITS-1], i_in_data.start_x};
        dy  = {i_in_data.end_y[COORD_BITS-1], i_in_data.end_y}
            - {i_in_data.start_y[COORD_BITS-1], i_in_data.start_y};
        adx = dx[EXT_BITS-1] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        ady = dy[EXT_BITS-1] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        x_major = adx > ady;
    end

    // classify the request
    always_comb begin
        o_cmd.first_x         = i_in_data.start_x;
        o_cmd.first_y         = i_in_data.start_y;
        o_cmd.major_end       = x_major ? i_in_data.end_x : i_in_data.end_y;
        o_cmd.major_delta     = x_major ? adx : ady;
        o_cmd.minor_delta     = x_major ? ady : adx;
        o_cmd.step_x_negative = dx[EXT_BITS-1];
        o_cmd.step_y_negative = dy[EXT_BITS-1];
        o_cmd.x_is_major      = x_major;
        o_cmd.color           = i_in_data.color;
        if (i_in_data.operation == OP_STEP) begin
            o_cmd.kind = CMD_STEP;
        end else if (miss) begin
            o_cmd.kind = CMD_REJECT;
        end else begin
            o_cmd.kind = CMD_LOAD;
        end
    end

endmodule

### rtl/core/clr_queue.sv
module clr_queue
    import clr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int DEPTH = 2;

    t_cmd       r_mem [DEPTH];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    assign o_ready = (r_count != 2'(DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // pointer and fill count
    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/core/clr_back.sv
module clr_back
    import clr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_area     i_area,
    output t_q_ctrl   o_q,
    input  logic      i_q_valid,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // line state
    logic signed [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic signed [COORD_BITS-1:0] r_cur_y, n_cur_y;
    logic signed [COORD_BITS-1:0] r_major_end;
    logic [COORD_BITS-1:0]        r_major_delta, r_minor_delta;
    logic signed [ERR_BITS-1:0]   r_err, n_err;
    logic                         r_sx_neg, r_sy_neg, r_x_major;
    logic [COLOR_BITS-1:0]        r_color;
    logic                         r_busy, n_busy;

    // pixel stage
    logic                         r_a_valid, n_a_valid;
    logic signed [COORD_BITS-1:0] r_a_x, n_a_x, r_a_y, n_a_y;
    logic [COLOR_BITS-1:0]        r_a_color, n_a_color;
    logic                         r_a_in, n_a_in, r_a_last, n_a_last;
    logic [WIDTH_BITS-1:0]        r_a_width, n_a_width;

    // multiply stage
    logic                         r_b_valid;
    logic signed [COORD_BITS-1:0] r_b_x, r_b_y;
    logic [COLOR_BITS-1:0]        r_b_color;
    logic                         r_b_in, r_b_last;
    logic [OFFSET_BITS-1:0]       r_b_prod;
    logic [WIDTH_BITS+AREA_BITS-1:0] b_prod_full;

    // output register
    logic                         r_c_valid;
    t_out_item                    r_c_data;

    logic c_can, b_can, a_can, pop;
    logic is_last, in_area;
    logic signed [ERR_BITS-1:0] err_add;
    logic signed [COORD_BITS-1:0] sx, sy;

    // stall chain from the output side
    assign c_can = !r_c_valid || i_out_ready;
    assign b_can = !r_b_valid || c_can;
    assign a_can = !r_a_valid || b_can;
    assign pop   = i_q_valid && a_can;

    assign o_q.pop = pop;

    assign o_out_valid = r_c_valid;
    assign o_out_data  = r_c_data;

    // current pixel classification
    always_comb begin
        is_last = (r_x_major ? r_cur_x : r_cur_y) == r_major_end;
        in_area = !(coord_lt_area(r_cur_x, i_area.left) || coord_gt_area(r_cur_x, i_area.right)
                 || coord_lt_area(r_cur_y, i_area.top) || coord_gt_area(r_cur_y, i_area.bottom));
        sx      = r_sx_neg ? -COORD_BITS'(1) : COORD_BITS'(1);
        sy      = r_sy_neg ? -COORD_BITS'(1) : COORD_BITS'(1);
        err_add = r_err + $signed({2'b00, r_minor_delta, 1'b0});
        if (i_area.right >= i_area.left) begin
            n_a_width = WIDTH_BITS'(i_area.right) - WIDTH_BITS'(i_area.left) + WIDTH_BITS'(1);
        end else begin
            n_a_width = WIDTH_BITS'(i_area.left) - WIDTH_BITS'(i_area.right) + WIDTH_BITS'(1);
        end
    end

    // bresenham step and command execution
    always_comb begin
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_err     = r_err;
        n_busy    = r_busy;
        n_a_valid = a_can ? 1'b0 : r_a_valid;
        n_a_x     = r_cur_x;
        n_a_y     = r_cur_y;
        n_a_color = r_color;
        n_a_in    = in_area;
        n_a_last  = is_last;
        if (pop) begin
            case (i_cmd.kind)
                CMD_LOAD: begin
                    n_busy  = 1'b1;
                    n_cur_x = i_cmd.first_x;
                    n_cur_y = i_cmd.first_y;
                    n_err   = '0;
                end
                CMD_REJECT: begin
                    n_busy    = 1'b0;
                    n_a_valid = 1'b1;
                    n_a_x     = '0;
                    n_a_y     = '0;
                    n_a_color = '0;
                    n_a_in    = 1'b0;
                    n_a_last  = 1'b1;
                end
                CMD_STEP: begin
                    if (r_busy) begin
                        n_a_valid = 1'b1;
                        if (is_last) begin
                            n_busy = 1'b0;
                        end else begin
                            if (r_x_major) begin
                                n_cur_x = r_cur_x + sx;
                            end else begin
                                n_cur_y = r_cur_y + sy;
                            end
                            n_err = err_add;
                            if (err_add >= $signed({3'b000, r_major_delta})) begin
                                if (r_x_major) begin
                                    n_cur_y = r_cur_y + sy;
                                end else begin
                                    n_cur_x = r_cur_x + sx;
                                end
                                n_err = err_add - $signed({2'b00, r_major_delta, 1'b0});
                            end
                        end
                    end
                end
                default: begin
                    n_busy = r_busy;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_a_valid <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_a_valid <= n_a_valid;
        end
    end

    // line state and pixel stage payload
    always_ff @(posedge i_clk) begin
        r_cur_x <= n_cur_x;
        r_cur_y <= n_cur_y;
        r_err   <= n_err;
        if (pop && i_cmd.kind == CMD_LOAD) begin
            r_major_end   <= i_cmd.major_end;
            r_major_delta <= i_cmd.major_delta;
            r_minor_delta <= i_cmd.minor_delta;
            r_sx_neg      <= i_cmd.step_x_negative;
            r_sy_neg      <= i_cmd.step_y_negative;
            r_x_major     <= i_cmd.x_is_major;
            r_color       <= i_cmd.color;
        end
        if (a_can) begin
            r_a_x     <= n_a_x;
            r_a_y     <= n_a_y;
            r_a_color <= n_a_color;
            r_a_in    <= n_a_in;
            r_a_last  <= n_a_last;
            r_a_width <= n_a_width;
        end
    end

    // row offset product
    assign b_prod_full = r_a_width * r_a_y[AREA_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_can) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_can) begin
            r_b_x     <= r_a_x;
            r_b_y     <= r_a_y;
            r_b_color <= r_a_color;
            r_b_in    <= r_a_in;
            r_b_last  <= r_a_last;
            r_b_prod  <= b_prod_full[OFFSET_BITS-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_can) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_can) begin
            r_c_data.pixel_x      <= r_b_x;
            r_c_data.pixel_y      <= r_b_y;
            r_c_data.pixel_offset <= r_b_in
                ? r_b_prod + {{(OFFSET_BITS-AREA_BITS){1'b0}}, r_b_x[AREA_BITS-1:0]}
                : '0;
            r_c_data.pixel_color  <= r_b_color;
            r_c_data.write_enable <= r_b_in;
            r_c_data.last_pixel   <= r_b_last;
        end
    end

endmodule

### rtl/core/clipped_line_rasterizer_unit.sv
// Bresenham line rasterizer with clipping to a configurable area. A start
// request (operation 0) loads two endpoints and a color; if the line's bounding
// box misses the area, one result comes out with write_enable 0 and last_pixel
// 1, otherwise no result. Each step request (operation 1) then gives one pixel,
// max(|dx|,|dy|)+1 in all, last_pixel on the final one; steps while no line is
// active give nothing. Requests are accepted one per clock while the queue has room:
// the front end classifies a request into a two-entry queue and the back end
// executes one queue entry per cycle while the output is not stalled, so
// sustained throughput is one pixel per clock. A pixel reaches the output
// through the queue and then the pixel, multiply and output registers. Area
// registers may only be written while no line work is outstanding.
module clipped_line_rasterizer_unit
    import clr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in_item                i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out_item               o_out_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [AREA_BITS-1:0]    i_cfg_data
);

    t_area   r_area;
    logic    push;
    t_cmd    push_cmd, head_cmd;
    logic    q_valid;
    t_q_ctrl q_ctrl;

    assign o_cfg_ready = 1'b1;

    // area registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area.left   <= AREA_LEFT_RST;
            r_area.top    <= AREA_TOP_RST;
            r_area.right  <= AREA_RIGHT_RST;
            r_area.bottom <= AREA_BOTTOM_RST;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_AREA_LEFT:   r_area.left   <= i_cfg_data;
                REG_AREA_TOP:    r_area.top    <= i_cfg_data;
                REG_AREA_RIGHT:  r_area.right  <= i_cfg_data;
                REG_AREA_BOTTOM: r_area.bottom <= i_cfg_data;
                default: begin
                    r_area <= r_area;
                end
            endcase
        end
    end

    clr_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_area     (r_area),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    clr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (o_in_ready),
        .i_pop   (q_ctrl.pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    clr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_area      (r_area),
        .o_q         (q_ctrl),
        .i_q_valid   (q_valid),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/core/clr_checker.sv
module clr_checker
    import clr_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input t_out_item               o_out_data
);

    // nothing on the output right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // clipped pixels and rejects carry no offset
    a_clip_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.write_enable |-> o_out_data.pixel_offset == '0)
        else $error("offset set on a pixel that is not written");

    // written pixels lie at nonnegative coordinates
    a_write_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.write_enable
            |-> !o_out_data.pixel_x[COORD_BITS-1] && !o_out_data.pixel_y[COORD_BITS-1])
        else $error("written pixel at negative coordinate");

endmodule

bind clipped_line_rasterizer_unit clr_checker u_clr_checker (.*);
